// ===== rtl/core/ssstat_pkg.sv =====
// Shared widths, step counts, datapath operation codes and command type for the statistics block.
`timescale 1ns / 1ps
`default_nettype none
package ssstat_pkg;

   localparam int SAMPLE_W = 24;
   localparam int COUNT_W  = 17;
   localparam int SUM_W    = 41;
   localparam int MAG_W    = 40;
   localparam int SUMSQ_W  = 63;
   localparam int SQ_W     = 47;
   localparam int WIDE_W   = 80;
   localparam int ROOT_W   = 64;
   localparam int REM_W    = 17;
   localparam int STEP_W   = 7;

   localparam int DIV_STEPS  = WIDE_W;
   localparam int MULN_STEPS = COUNT_W;
   localparam int MULS_STEPS = MAG_W;
   localparam int SQRT_STEPS = ROOT_W / 2;

   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
   localparam logic [STEP_W-1:0] MULN_LAST = STEP_W'(MULN_STEPS - 1);
   localparam logic [STEP_W-1:0] MULS_LAST = STEP_W'(MULS_STEPS - 1);
   localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);

   localparam logic signed [SAMPLE_W-1:0] MIN_INIT = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] MAX_INIT = 24'sh800000;
   localparam logic [SAMPLE_W-1:0]        DEV_SAT  = 24'hFFFFFF;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_START,
      OP_DIV_STEP,
      OP_MULN_LOAD,
      OP_MUL_STEP,
      OP_MULS_LOAD,
      OP_SUBTRACT,
      OP_DIV_AGAIN,
      OP_SQRT_LOAD,
      OP_SQRT_STEP,
      OP_FINISH
   } op_type;

   typedef struct packed {
      logic   accept;
      op_type op;
   } cmd_type;

endpackage
`default_nettype wire

// ===== rtl/core/ssstat_ctrl.sv =====
// Sequencer: input handshake, phase ordering of the closing computation, result valid.
`timescale 1ns / 1ps
`default_nettype none
module ssstat_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_last,
   output logic                     req_ready,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output ssstat_pkg::cmd_type      cmd
);

   typedef enum logic [13:0] {
      S_IDLE       = 14'b00000000000001,
      S_DRAIN      = 14'b00000000000010,
      S_DIV_AVG    = 14'b00000000000100,
      S_AVG_DONE   = 14'b00000000001000,
      S_MUL_N      = 14'b00000000010000,
      S_MUL_N_DONE = 14'b00000000100000,
      S_MUL_S      = 14'b00000001000000,
      S_SUB        = 14'b00000010000000,
      S_DIV_1      = 14'b00000100000000,
      S_DIV_MID    = 14'b00001000000000,
      S_DIV_2      = 14'b00010000000000,
      S_SQRT_LOAD  = 14'b00100000000000,
      S_SQRT       = 14'b01000000000000,
      S_DONE       = 14'b10000000000000
   } state_type;

   state_type                         state_ff, state_in;
   logic [ssstat_pkg::STEP_W-1:0]     cnt_ff, cnt_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = '0;
      cmd.op     = ssstat_pkg::OP_NONE;
      req_ready  = (state_ff == S_IDLE);
      cmd.accept = req_valid && req_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            cmd.op   = ssstat_pkg::OP_START;
            state_in = S_DIV_AVG;
         end
         S_DIV_AVG: begin
            cmd.op = ssstat_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ssstat_pkg::DIV_LAST) state_in = S_AVG_DONE;
         end
         S_AVG_DONE: begin
            cmd.op   = ssstat_pkg::OP_MULN_LOAD;
            state_in = S_MUL_N;
         end
         S_MUL_N: begin
            cmd.op = ssstat_pkg::OP_MUL_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ssstat_pkg::MULN_LAST) state_in = S_MUL_N_DONE;
         end
         S_MUL_N_DONE: begin
            cmd.op   = ssstat_pkg::OP_MULS_LOAD;
            state_in = S_MUL_S;
         end
         S_MUL_S: begin
            cmd.op = ssstat_pkg::OP_MUL_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ssstat_pkg::MULS_LAST) state_in = S_SUB;
         end
         S_SUB: begin
            cmd.op   = ssstat_pkg::OP_SUBTRACT;
            state_in = S_DIV_1;
         end
         S_DIV_1: begin
            cmd.op = ssstat_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ssstat_pkg::DIV_LAST) state_in = S_DIV_MID;
         end
         S_DIV_MID: begin
            cmd.op   = ssstat_pkg::OP_DIV_AGAIN;
            state_in = S_DIV_2;
         end
         S_DIV_2: begin
            cmd.op = ssstat_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ssstat_pkg::DIV_LAST) state_in = S_SQRT_LOAD;
         end
         S_SQRT_LOAD: begin
            cmd.op   = ssstat_pkg::OP_SQRT_LOAD;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = ssstat_pkg::OP_SQRT_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ssstat_pkg::SQRT_LAST) state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op   = ssstat_pkg::OP_FINISH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = (cmd.op == ssstat_pkg::OP_FINISH) || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/ssstat_dpath.sv =====
// Datapath: running accumulators, shift-add multiplier, restoring divider, square root, result word.
`timescale 1ns / 1ps
`default_nettype none
module ssstat_dpath #(
   parameter int MAX_SAMPLES = 65536
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire ssstat_pkg::cmd_type                   cmd,
   input  wire logic signed [ssstat_pkg::SAMPLE_W-1:0] req_sample,
   output logic signed [ssstat_pkg::SAMPLE_W-1:0]     rsp_minimum,
   output logic signed [ssstat_pkg::SAMPLE_W-1:0]     rsp_maximum,
   output logic signed [ssstat_pkg::SAMPLE_W-1:0]     rsp_average,
   output logic [ssstat_pkg::SAMPLE_W-1:0]            rsp_deviation,
   output logic [ssstat_pkg::COUNT_W-1:0]             rsp_sample_count
);

   localparam int SW = ssstat_pkg::SAMPLE_W;
   localparam int CW = ssstat_pkg::COUNT_W;
   localparam int WW = ssstat_pkg::WIDE_W;
   localparam int RW = ssstat_pkg::ROOT_W;
   localparam logic [CW-1:0] COUNT_MAX = MAX_SAMPLES[CW-1:0];

   // running accumulators
   logic [CW-1:0]                          count_ff, count_in;
   logic signed [SW-1:0]                   min_ff, min_in;
   logic signed [SW-1:0]                   max_ff, max_in;
   logic signed [ssstat_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [ssstat_pkg::SUMSQ_W-1:0]         sumsq_ff, sumsq_in;
   logic [ssstat_pkg::SQ_W-1:0]            sq_ff, sq_in;
   logic                                   sq_add_ff, sq_add_in;

   // closing computation
   logic [WW-1:0]                          acc_ff, acc_in;
   logic [WW-1:0]                          prod_ff, prod_in;
   logic [WW-1:0]                          mcand_ff, mcand_in;
   logic [ssstat_pkg::MAG_W-1:0]           mplier_ff, mplier_in;
   logic [ssstat_pkg::REM_W-1:0]           rem_ff, rem_in;
   logic [RW-1:0]                          x_ff, x_in;
   logic [RW-1:0]                          res_ff, res_in;
   logic [RW-1:0]                          bit_ff, bit_in;
   logic signed [SW-1:0]                   avg_ff, avg_in;

   // result word
   logic signed [SW-1:0]                   out_min_ff, out_max_ff, out_avg_ff;
   logic [SW-1:0]                          out_dev_ff;
   logic [CW-1:0]                          out_count_ff;

   logic                                   take;
   logic signed [2*SW-1:0]                 square;
   logic signed [ssstat_pkg::SUM_W-1:0]    neg_sum;
   logic [ssstat_pkg::MAG_W-1:0]           mag;
   logic [ssstat_pkg::REM_W:0]             trial, trial_diff;
   logic                                   fits;
   logic [WW:0]                            wide_diff;
   logic [RW-1:0]                          root_trial;
   logic [SW-1:0]                          quot;
   logic [SW-1:0]                          dev_sat;

   assign take    = cmd.accept && (count_ff < COUNT_MAX);
   assign square  = req_sample * req_sample;
   assign neg_sum = -sum_ff;
   assign mag     = sum_ff[ssstat_pkg::SUM_W-1] ? neg_sum[ssstat_pkg::MAG_W-1:0]
                                                 : sum_ff[ssstat_pkg::MAG_W-1:0];

   // one restoring division step against the sample count
   assign trial      = {rem_ff, acc_ff[WW-1]};
   assign fits       = trial >= {1'b0, count_ff};
   assign trial_diff = trial - {1'b0, count_ff};

   assign wide_diff  = {1'b0, prod_ff} - {1'b0, acc_ff};
   assign root_trial = res_ff + bit_ff;
   assign quot       = acc_ff[SW-1:0];
   assign dev_sat    = (|res_ff[RW-1:SW]) ? ssstat_pkg::DEV_SAT : res_ff[SW-1:0];

   always_comb begin
      count_in  = count_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      sum_in    = sum_ff;
      sumsq_in  = sumsq_ff;
      sq_in     = square[ssstat_pkg::SQ_W-1:0];
      sq_add_in = take;
      if (sq_add_ff) sumsq_in = sumsq_ff + {{(ssstat_pkg::SUMSQ_W-ssstat_pkg::SQ_W){1'b0}}, sq_ff};
      if (cmd.op == ssstat_pkg::OP_FINISH) begin
         count_in = '0;
         min_in   = ssstat_pkg::MIN_INIT;
         max_in   = ssstat_pkg::MAX_INIT;
         sum_in   = '0;
         sumsq_in = '0;
      end else if (take) begin
         count_in = count_ff + 1'b1;
         if (req_sample < min_ff) min_in = req_sample;
         if (req_sample > max_ff) max_in = req_sample;
         sum_in = sum_ff + {{(ssstat_pkg::SUM_W-SW){req_sample[SW-1]}}, req_sample};
      end
   end

   always_comb begin
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      x_in      = x_ff;
      res_in    = res_ff;
      bit_in    = bit_ff;
      avg_in    = avg_ff;
      case (cmd.op)
         ssstat_pkg::OP_START: begin
            acc_in = {{(WW-ssstat_pkg::MAG_W){1'b0}}, mag};
            rem_in = '0;
         end
         ssstat_pkg::OP_DIV_STEP: begin
            acc_in = {acc_ff[WW-2:0], fits};
            rem_in = fits ? trial_diff[ssstat_pkg::REM_W-1:0] : trial[ssstat_pkg::REM_W-1:0];
         end
         ssstat_pkg::OP_MULN_LOAD: begin
            // truncate toward zero: negate the magnitude quotient
            avg_in    = sum_ff[ssstat_pkg::SUM_W-1] ? -quot : quot;
            acc_in    = '0;
            mcand_in  = {{(WW-ssstat_pkg::SUMSQ_W){1'b0}}, sumsq_ff};
            mplier_in = {{(ssstat_pkg::MAG_W-CW){1'b0}}, count_ff};
         end
         ssstat_pkg::OP_MUL_STEP: begin
            if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
            mcand_in  = {mcand_ff[WW-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[ssstat_pkg::MAG_W-1:1]};
         end
         ssstat_pkg::OP_MULS_LOAD: begin
            prod_in   = acc_ff;
            acc_in    = '0;
            mcand_in  = {{(WW-ssstat_pkg::MAG_W){1'b0}}, mag};
            mplier_in = mag;
         end
         ssstat_pkg::OP_SUBTRACT: begin
            acc_in = wide_diff[WW] ? '0 : wide_diff[WW-1:0];
            rem_in = '0;
         end
         ssstat_pkg::OP_DIV_AGAIN: begin
            rem_in = '0;
         end
         ssstat_pkg::OP_SQRT_LOAD: begin
            x_in   = acc_ff[RW-1:0];
            res_in = '0;
            bit_in = {2'b01, {(RW-2){1'b0}}};
         end
         ssstat_pkg::OP_SQRT_STEP: begin
            if (x_ff >= root_trial) begin
               x_in   = x_ff - root_trial;
               res_in = {1'b0, res_ff[RW-1:1]} + bit_ff;
            end else begin
               res_in = {1'b0, res_ff[RW-1:1]};
            end
            bit_in = {2'b00, bit_ff[RW-1:2]};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         min_ff    <= ssstat_pkg::MIN_INIT;
         max_ff    <= ssstat_pkg::MAX_INIT;
         sum_ff    <= '0;
         sumsq_ff  <= '0;
         sq_add_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
         sum_ff    <= sum_in;
         sumsq_ff  <= sumsq_in;
         sq_add_ff <= sq_add_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff     <= sq_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
      x_ff      <= x_in;
      res_ff    <= res_in;
      bit_ff    <= bit_in;
      avg_ff    <= avg_in;
      if (cmd.op == ssstat_pkg::OP_FINISH) begin
         out_min_ff   <= min_ff;
         out_max_ff   <= max_ff;
         out_avg_ff   <= avg_ff;
         out_dev_ff   <= dev_sat;
         out_count_ff <= count_ff;
      end
   end

   assign rsp_minimum      = out_min_ff;
   assign rsp_maximum      = out_max_ff;
   assign rsp_average      = out_avg_ff;
   assign rsp_deviation    = out_dev_ff;
   assign rsp_sample_count = out_count_ff;

endmodule
`default_nettype wire

// ===== rtl/core/sample_set_min_max_mean_stddev.sv =====
// Top level of the sample-set statistics block: minimum, maximum, mean and standard deviation.
`timescale 1ns / 1ps
`default_nettype none
// Samples (signed thousandths) are taken one word per cycle while req_ready is high; a word
// with req_last set closes the set. Up to MAX_SAMPLES samples are accumulated, later ones
// are dropped. A closing word starts a sequenced computation that holds req_ready low: an
// 80-step restoring divider (run three times: mean, then twice for the variance), a
// shift-add multiplier (17 steps for n*sum_sq, 40 for sum^2) and a 32-step square root. The
// result sits in an output register; sampling of the next set goes on while it waits, and
// the next closing word only stalls at the end if it is still unclaimed.
module sample_set_min_max_mean_stddev #(
   parameter int MAX_SAMPLES = 65536
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [ssstat_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic                                   req_last,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [ssstat_pkg::SAMPLE_W-1:0]      rsp_minimum,
   output logic signed [ssstat_pkg::SAMPLE_W-1:0]      rsp_maximum,
   output logic signed [ssstat_pkg::SAMPLE_W-1:0]      rsp_average,
   output logic [ssstat_pkg::SAMPLE_W-1:0]             rsp_deviation,
   output logic [ssstat_pkg::COUNT_W-1:0]              rsp_sample_count
);

   ssstat_pkg::cmd_type cmd;

   ssstat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   ssstat_dpath #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_sample       (req_sample),
      .rsp_minimum      (rsp_minimum),
      .rsp_maximum      (rsp_maximum),
      .rsp_average      (rsp_average),
      .rsp_deviation    (rsp_deviation),
      .rsp_sample_count (rsp_sample_count)
   );

endmodule
`default_nettype wire

// ===== tb/sample_set_min_max_mean_stddev_test.sv =====
// Self-checking testbench for the sample-set statistics block: min, max, mean and deviation.
`timescale 1ns / 1ps
module sample_set_min_max_mean_stddev_test;

   localparam int SAMPLE_W = ssstat_pkg::SAMPLE_W;
   localparam int COUNT_W  = ssstat_pkg::COUNT_W;
   localparam int SUM_W    = ssstat_pkg::SUM_W;
   localparam int SUMSQ_W  = ssstat_pkg::SUMSQ_W;
   localparam int MAG_W    = ssstat_pkg::MAG_W;

   localparam logic signed [SAMPLE_W-1:0] MIN_INIT = ssstat_pkg::MIN_INIT;
   localparam logic signed [SAMPLE_W-1:0] MAX_INIT = ssstat_pkg::MAX_INIT;
   localparam logic [SAMPLE_W-1:0]        DEV_SAT  = ssstat_pkg::DEV_SAT;

   localparam int SET_LIMIT     = 65536;
   localparam int RANDOM_WORDS  = 1500;
   localparam int EXTREME_WORDS = 200;
   localparam int IDLE_LIMIT    = 4000;
   localparam int DRAIN_CYCLES  = 400;
   localparam int REPORT_LINES  = 20;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP    = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_BOTTOM = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef struct {
      logic signed [SAMPLE_W-1:0] minimum;
      logic signed [SAMPLE_W-1:0] maximum;
      logic signed [SAMPLE_W-1:0] average;
      logic [SAMPLE_W-1:0]        deviation;
      logic [COUNT_W-1:0]         sample_count;
   } set_stats_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_valid  = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       req_last   = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready  = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_minimum;
   logic signed [SAMPLE_W-1:0] rsp_maximum;
   logic signed [SAMPLE_W-1:0] rsp_average;
   logic [SAMPLE_W-1:0]        rsp_deviation;
   logic [COUNT_W-1:0]         rsp_sample_count;

   // running statistics of the set being collected
   logic [COUNT_W-1:0]         acc_count  = '0;
   logic signed [SAMPLE_W-1:0] acc_min    = MIN_INIT;
   logic signed [SAMPLE_W-1:0] acc_max    = MAX_INIT;
   logic signed [SUM_W-1:0]    acc_sum    = '0;
   logic [SUMSQ_W-1:0]         acc_sum_sq = '0;
   set_stats_type              pending_stats[$];
   set_stats_type              oldest_stats;

   int gap_max         = 0;
   int stall_max       = 0;
   int burst_left      = 0;
   int ready_run       = 0;
   int idle_cycles     = 0;
   int words_sent      = 0;
   int sets_closed     = 0;
   int results_checked = 0;
   int mismatch_count  = 0;

   sample_set_min_max_mean_stddev #(
      .MAX_SAMPLES(SET_LIMIT)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_minimum     (rsp_minimum),
      .rsp_maximum     (rsp_maximum),
      .rsp_average     (rsp_average),
      .rsp_deviation   (rsp_deviation),
      .rsp_sample_count(rsp_sample_count)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] floor_root(input logic [63:0] x);
      logic [31:0] root;
      logic [31:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         if (64'(trial) * 64'(trial) <= x) root = trial;
      end
      return root;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9)) inside
         0: begin
            return $urandom_range(1) ? SAMPLE_TOP : SAMPLE_BOTTOM;
         end
         [1:3]: begin
            return SAMPLE_W'($urandom_range(0, 2000)) - SAMPLE_W'(1000);
         end
         default: begin
            return SAMPLE_W'($urandom);
         end
      endcase
   endfunction

   // Fold one accepted word into the running set; on a closing word queue the
   // expected statistics and start a fresh set.
   task automatic predict_word(input logic signed [SAMPLE_W-1:0] s, input logic last);
      logic [MAG_W-1:0] mag;
      logic [MAG_W-1:0] quot;
      logic [127:0]     spread;
      logic [127:0]     square_of_sum;
      logic [31:0]      root;
      set_stats_type    stats;
      if (acc_count < COUNT_W'(SET_LIMIT)) begin
         acc_count = acc_count + 1'b1;
         if (s < acc_min) acc_min = s;
         if (s > acc_max) acc_max = s;
         acc_sum    = acc_sum + SUM_W'(s);
         acc_sum_sq = acc_sum_sq + SUMSQ_W'(longint'(s) * longint'(s));
      end
      if (!last) return;
      stats.minimum      = acc_min;
      stats.maximum      = acc_max;
      stats.sample_count = acc_count;
      stats.average      = '0;
      stats.deviation    = '0;
      if (acc_count != 0) begin
         mag  = (acc_sum < 0) ? MAG_W'(-acc_sum) : MAG_W'(acc_sum);
         quot = mag / MAG_W'(acc_count);
         stats.average = (acc_sum < 0) ? SAMPLE_W'(-quot) : SAMPLE_W'(quot);
         // n*sum_sq - sum^2 is exact at 128 bits; both floors follow
         spread        = 128'(acc_count) * 128'(acc_sum_sq);
         square_of_sum = 128'(mag) * 128'(mag);
         spread = (spread >= square_of_sum) ? spread - square_of_sum : '0;
         spread = spread / 128'(acc_count) / 128'(acc_count);
         root   = floor_root(spread[63:0]);
         stats.deviation = (root > 32'(DEV_SAT)) ? DEV_SAT : root[SAMPLE_W-1:0];
      end
      pending_stats.push_back(stats);
      sets_closed++;
      acc_count  = '0;
      acc_min    = MIN_INIT;
      acc_max    = MAX_INIT;
      acc_sum    = '0;
      acc_sum_sq = '0;
   endtask

   // Present one word and hold it until accepted; open a gap between bursts.
   task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      req_last   <= last;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      words_sent++;
      predict_word(s, last);
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LINES) $display("@%0t mismatch: %s", $realtime, msg);
   endtask

   task automatic test_directed_sets();
      gap_max   = 2;
      stall_max = 3;
      send_word(SAMPLE_TOP, 1'b1);
      send_word(SAMPLE_BOTTOM, 1'b1);
      send_word('0, 1'b1);
      send_word(SAMPLE_TOP, 1'b0);
      send_word(SAMPLE_BOTTOM, 1'b1);
      // negative and positive means that truncate toward zero
      send_word(-24'sd1, 1'b0);
      send_word(-24'sd2, 1'b1);
      send_word(24'sd5, 1'b0);
      send_word(24'sd6, 1'b1);
      send_word(SAMPLE_BOTTOM, 1'b0);
      send_word(SAMPLE_BOTTOM, 1'b0);
      send_word(SAMPLE_BOTTOM, 1'b1);
      send_word(SAMPLE_TOP, 1'b0);
      send_word(SAMPLE_TOP, 1'b0);
      send_word(SAMPLE_TOP, 1'b1);
      send_word(24'sd1, 1'b0);
      send_word(-24'sd1, 1'b0);
      send_word(24'sd1, 1'b0);
      send_word(-24'sd1, 1'b1);
   endtask

   task automatic test_random_sets();
      int                         set_len;
      int                         words_left;
      logic signed [SAMPLE_W-1:0] held;
      logic                       repeat_value;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin gap_max = 0;  stall_max = 0;   end
            1: begin gap_max = 4;  stall_max = 0;   end
            2: begin gap_max = 0;  stall_max = 12;  end
            3: begin gap_max = 6;  stall_max = 40;  end
            default: begin gap_max = 20; stall_max = 300; end
         endcase
         words_left = RANDOM_WORDS / 5;
         while (words_left > 0) begin
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 300)
                                                  : $urandom_range(1, 20);
            repeat_value = ($urandom_range(0, 11) == 0);
            held = pick_sample();
            for (int i = 0; i < set_len; i++)
               send_word(repeat_value ? held : pick_sample(), i == set_len - 1);
            words_left -= set_len;
         end
      end
   endtask

   task automatic test_extreme_sets();
      gap_max   = 0;
      stall_max = 0;
      // long set of extremes: widest sums and deviation
      for (int i = 0; i < EXTREME_WORDS; i++)
         send_word($urandom_range(1) ? SAMPLE_TOP : SAMPLE_BOTTOM, i == EXTREME_WORDS - 1);
      send_word(SAMPLE_BOTTOM, 1'b0);
      send_word(SAMPLE_TOP, 1'b0);
      send_word(SAMPLE_TOP, 1'b1);
   endtask

   // result checker and receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_run = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_stats.size() == 0) begin
               report_mismatch($sformatf("result with no closed set, count %0d",
                                         rsp_sample_count));
            end else begin
               oldest_stats = pending_stats.pop_front();
               results_checked++;
               if (rsp_minimum !== oldest_stats.minimum)
                  report_mismatch($sformatf("set %0d minimum %0d, expected %0d",
                                            results_checked, rsp_minimum,
                                            oldest_stats.minimum));
               if (rsp_maximum !== oldest_stats.maximum)
                  report_mismatch($sformatf("set %0d maximum %0d, expected %0d",
                                            results_checked, rsp_maximum,
                                            oldest_stats.maximum));
               if (rsp_average !== oldest_stats.average)
                  report_mismatch($sformatf("set %0d average %0d, expected %0d",
                                            results_checked, rsp_average,
                                            oldest_stats.average));
               if (rsp_deviation !== oldest_stats.deviation)
                  report_mismatch($sformatf("set %0d deviation %0d, expected %0d",
                                            results_checked, rsp_deviation,
                                            oldest_stats.deviation));
               if (rsp_sample_count !== oldest_stats.sample_count)
                  report_mismatch($sformatf("set %0d sample count %0d, expected %0d",
                                            results_checked, rsp_sample_count,
                                            oldest_stats.sample_count));
            end
         end
         if (ready_run > 0) begin
            ready_run--;
         end else if (stall_max == 0) begin
            rsp_ready <= 1'b1;
         end else if (rsp_ready) begin
            rsp_ready <= 1'b0;
            ready_run = $urandom_range(0, stall_max - 1);
         end else begin
            rsp_ready <= 1'b1;
            ready_run = $urandom_range(0, 15);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("no word moved for %0d cycles", IDLE_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_sets();
      test_random_sets();
      test_extreme_sets();
      req_valid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d sample words in %0d sets checked, single samples to %0d-word extreme sets",
               words_sent, results_checked, EXTREME_WORDS);
      $display("sender gaps up to 20 cycles, result stalls up to 300 cycles, %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/ssstat_pkg.sv
rtl/core/ssstat_ctrl.sv
rtl/core/ssstat_dpath.sv
rtl/core/sample_set_min_max_mean_stddev.sv
tb/sample_set_min_max_mean_stddev_test.sv
